// File: src/dctm_pkg.sv
// Shared constants, register codes and item types for the dark channel tile minimum block.
`timescale 1ns / 1ps

package dctm_pkg;

	// Limits of the supported image and tile geometry.
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int MAX_TILE   = 64;

	// Field and counter widths.
	localparam int PIX_W  = 8;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int TIC_W  = $clog2(MAX_TILE);
	localparam int TS_W   = 7;
	localparam int DIM_W  = 12;
	localparam int CIDX_W = 2;

	// Result queue geometry.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	// Register reset values.
	localparam logic [TS_W-1:0]  TILE_SIZE_RST    = TS_W'(14);
	localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = DIM_W'(480);

	// Configuration register indexes.
	typedef enum logic [CIDX_W-1:0] {
		REG_TILE_SIZE    = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} cfg_reg_t;

	// Per-item control from the position tracker.
	typedef struct packed {
		logic [COL_W-1:0] idx;
		logic             first;
		logic             emit;
		logic [ROW_W-1:0] tile_row;
		logic             frame_end;
	} tile_info_t;

	// One finished tile.
	typedef struct packed {
		logic             frame_end;
		logic [ROW_W-1:0] tile_row;
		logic [COL_W-1:0] tile_column;
		logic [PIX_W-1:0] tile_minimum;
	} tile_res_t;

endpackage

// File: src/dctm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module dctm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; a read of the entry being written returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/dctm_pos.sv
// Raster position tracker: pixel, in-tile and tile counters with edge detection.
`timescale 1ns / 1ps

module dctm_pos (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [dctm_pkg::TS_W-1:0]      tile_size,
	input  logic [dctm_pkg::DIM_W-1:0]     image_width,
	input  logic [dctm_pkg::DIM_W-1:0]     image_height,
	input  logic                           advance,
	output dctm_pkg::tile_info_t           info,
	output logic                           at_origin
);

	logic [dctm_pkg::COL_W-1:0] pix_col_q;
	logic [dctm_pkg::ROW_W-1:0] pix_row_q;
	logic [dctm_pkg::TIC_W-1:0] col_in_tile_q;
	logic [dctm_pkg::TIC_W-1:0] row_in_tile_q;
	logic [dctm_pkg::COL_W-1:0] tile_x_q;
	logic [dctm_pkg::ROW_W-1:0] tile_y_q;

	logic [dctm_pkg::TS_W-1:0]  ts_eff;
	logic [dctm_pkg::TS_W-1:0]  ts_m1;
	logic [dctm_pkg::DIM_W-1:0] w_eff;
	logic [dctm_pkg::DIM_W-1:0] h_eff;
	logic [dctm_pkg::DIM_W-1:0] w_m1;
	logic [dctm_pkg::DIM_W-1:0] h_m1;
	logic                       row_last;
	logic                       frame_last;
	logic                       col_tile_end;
	logic                       row_tile_end;

	// Clamp the registers into their working ranges.
	always_comb begin
		if (tile_size == '0) begin
			ts_eff = dctm_pkg::TS_W'(1);
		end else if (tile_size > dctm_pkg::TS_W'(dctm_pkg::MAX_TILE)) begin
			ts_eff = dctm_pkg::TS_W'(dctm_pkg::MAX_TILE);
		end else begin
			ts_eff = tile_size;
		end
		if (image_width == '0) begin
			w_eff = dctm_pkg::DIM_W'(1);
		end else if (image_width > dctm_pkg::DIM_W'(dctm_pkg::MAX_WIDTH)) begin
			w_eff = dctm_pkg::DIM_W'(dctm_pkg::MAX_WIDTH);
		end else begin
			w_eff = image_width;
		end
		if (image_height == '0) begin
			h_eff = dctm_pkg::DIM_W'(1);
		end else if (image_height > dctm_pkg::DIM_W'(dctm_pkg::MAX_HEIGHT)) begin
			h_eff = dctm_pkg::DIM_W'(dctm_pkg::MAX_HEIGHT);
		end else begin
			h_eff = image_height;
		end
	end

	assign ts_m1 = ts_eff - dctm_pkg::TS_W'(1);
	assign w_m1  = w_eff - dctm_pkg::DIM_W'(1);
	assign h_m1  = h_eff - dctm_pkg::DIM_W'(1);

	// A counter at or past its end counts as being at the end.
	assign row_last     = dctm_pkg::DIM_W'(pix_col_q) >= w_m1;
	assign frame_last   = dctm_pkg::DIM_W'(pix_row_q) >= h_m1;
	assign col_tile_end = dctm_pkg::TS_W'(col_in_tile_q) >= ts_m1;
	assign row_tile_end = dctm_pkg::TS_W'(row_in_tile_q) >= ts_m1;

	// Control for the pixel now at the input.
	always_comb begin
		info.idx       = tile_x_q;
		info.first     = (col_in_tile_q == '0) && (row_in_tile_q == '0);
		info.emit      = (col_tile_end || row_last) && (row_tile_end || frame_last);
		info.tile_row  = tile_y_q;
		info.frame_end = row_last && frame_last;
	end

	assign at_origin = (pix_col_q == '0) && (pix_row_q == '0);

	// Step the raster position once per accepted pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_col_q     <= '0;
			pix_row_q     <= '0;
			col_in_tile_q <= '0;
			row_in_tile_q <= '0;
			tile_x_q      <= '0;
			tile_y_q      <= '0;
		end else if (advance) begin
			if (row_last) begin
				pix_col_q     <= '0;
				col_in_tile_q <= '0;
				tile_x_q      <= '0;
				if (frame_last) begin
					pix_row_q     <= '0;
					row_in_tile_q <= '0;
					tile_y_q      <= '0;
				end else begin
					pix_row_q <= pix_row_q + dctm_pkg::ROW_W'(1);
					if (row_tile_end) begin
						row_in_tile_q <= '0;
						tile_y_q      <= tile_y_q + dctm_pkg::ROW_W'(1);
					end else begin
						row_in_tile_q <= row_in_tile_q + dctm_pkg::TIC_W'(1);
					end
				end
			end else begin
				pix_col_q <= pix_col_q + dctm_pkg::COL_W'(1);
				if (col_tile_end) begin
					col_in_tile_q <= '0;
					tile_x_q      <= tile_x_q + dctm_pkg::COL_W'(1);
				end else begin
					col_in_tile_q <= col_in_tile_q + dctm_pkg::TIC_W'(1);
				end
			end
		end
	end

endmodule

// File: src/dctm_fifo.sv
// Small result queue that decouples the tile pipeline from the output stall.
`timescale 1ns / 1ps

module dctm_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  dctm_pkg::tile_res_t           push_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output dctm_pkg::tile_res_t           out_data,
	output logic [dctm_pkg::FIFO_CW-1:0]  count
);

	dctm_pkg::tile_res_t            slots_q [dctm_pkg::FIFO_DEPTH];
	logic [dctm_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [dctm_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [dctm_pkg::FIFO_CW-1:0]   count_q;
	logic                           pop;

	assign out_valid = count_q != '0;
	assign out_data  = slots_q[rd_ptr_q];
	assign count     = count_q;
	assign pop       = out_valid && out_ready;

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + dctm_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + dctm_pkg::FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + dctm_pkg::FIFO_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - dctm_pkg::FIFO_CW'(1);
			end
		end
	end

endmodule

// File: src/dark_channel_tile_min_core.sv
// Top level of the dark channel tile minimum block.
`timescale 1ns / 1ps

// Usage:
// Pixels enter on the s_ channel in raster order, one BGR item per accepted transfer.
// For every pixel the block takes the smallest colour byte and folds it into the
// running minimum of its tile, held in a 2048-entry memory with one entry per tile
// column. When the bottom-right pixel of a tile arrives, one item carrying the tile
// minimum and the tile coordinates leaves on the m_ channel; m_tlast marks the last
// tile of the frame. Other pixels produce no output item.
// Throughput is one pixel per cycle while s_tready is high. A tile result is queued
// for m_tvalid after the pixel that closes the tile passes the memory read in stage 1,
// then the update, write-back and queueing. A back-to-back update of the same
// entry is forwarded from the last write, so the memory port never stalls the stream.
// Results wait in a four-slot queue; when the receiver stalls, s_tready drops once
// three results are queued or in flight, and no result is lost.
// Configuration writes on cfg_ are always accepted and should be made while idle.
// Reset returns the registers to 14, 640 and 480 and the position to the frame origin;
// the memory needs no clearing, as each tile's first pixel overwrites its entry.
module dark_channel_tile_min_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,    // blue [7:0], green [15:8], red [23:16]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,    // tile_minimum [7:0], tile_column [18:8],
	                                                  // tile_row [29:19], zero [31:30]
	output logic                          m_tlast,    // frame_end
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dctm_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [dctm_pkg::DIM_W-1:0]    cfg_data
);

	logic [dctm_pkg::TS_W-1:0]   tile_size_q;
	logic [dctm_pkg::DIM_W-1:0]  image_width_q;
	logic [dctm_pkg::DIM_W-1:0]  image_height_q;

	logic                        accept;
	dctm_pkg::tile_info_t        info;
	logic                        at_origin;
	logic [dctm_pkg::PIX_W-1:0]  blue;
	logic [dctm_pkg::PIX_W-1:0]  green;
	logic [dctm_pkg::PIX_W-1:0]  red;
	logic [dctm_pkg::PIX_W-1:0]  bg_min;
	logic [dctm_pkg::PIX_W-1:0]  dark;

	logic                        s1_vld;
	dctm_pkg::tile_info_t        s1_info;
	logic [dctm_pkg::PIX_W-1:0]  s1_dark;

	logic [dctm_pkg::PIX_W-1:0]  ram_rdata;
	logic                        lw_vld_q;
	logic [dctm_pkg::COL_W-1:0]  lw_idx_q;
	logic [dctm_pkg::PIX_W-1:0]  lw_val_q;
	logic [dctm_pkg::PIX_W-1:0]  old_min;
	logic [dctm_pkg::PIX_W-1:0]  new_min;

	logic                        s1_push;
	dctm_pkg::tile_res_t         push_res;
	dctm_pkg::tile_res_t         head_res;
	logic [dctm_pkg::FIFO_CW-1:0] fifo_count;
	logic [dctm_pkg::FIFO_CW:0]  pending;

	// Configuration registers; writes to an unused index are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_size_q    <= dctm_pkg::TILE_SIZE_RST;
			image_width_q  <= dctm_pkg::IMAGE_WIDTH_RST;
			image_height_q <= dctm_pkg::IMAGE_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (dctm_pkg::cfg_reg_t'(cfg_index))
				dctm_pkg::REG_TILE_SIZE:    tile_size_q    <= cfg_data[dctm_pkg::TS_W-1:0];
				dctm_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				dctm_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input handshake: room is counted over queued results and the one in flight.
	assign pending  = dctm_pkg::FIFO_CW'(fifo_count) + (dctm_pkg::FIFO_CW + 1)'(s1_vld && s1_info.emit);
	assign s_tready = pending < (dctm_pkg::FIFO_CW + 1)'(dctm_pkg::FIFO_DEPTH - 1);
	assign accept   = s_tvalid && s_tready;

	// Dark channel value of the incoming pixel.
	assign blue   = s_tdata[7:0];
	assign green  = s_tdata[15:8];
	assign red    = s_tdata[23:16];
	assign bg_min = (blue < green) ? blue : green;
	assign dark   = (red < bg_min) ? red : bg_min;

	dctm_pos u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.tile_size    (tile_size_q),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.advance      (accept),
		.info         (info),
		.at_origin    (at_origin)
	);

	// Running minima, one entry per tile column.
	dctm_ram #(
		.WIDTH (dctm_pkg::PIX_W),
		.DEPTH (dctm_pkg::MAX_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (s1_vld),
		.waddr (s1_info.idx),
		.wdata (new_min),
		.re    (accept),
		.raddr (info.idx),
		.rdata (ram_rdata)
	);

	// Stage 1 holds the pixel while its memory entry is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
		end else begin
			s1_vld <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_info <= info;
			s1_dark <= dark;
		end
	end

	// The last write is the newest value of its entry, so it overrides a stale read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_vld_q <= 1'b0;
		end else if (s1_vld) begin
			lw_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_vld) begin
			lw_idx_q <= s1_info.idx;
			lw_val_q <= new_min;
		end
	end

	// Read, fold in the new pixel and write back; the first pixel of a tile restarts it.
	assign old_min = (lw_vld_q && (lw_idx_q == s1_info.idx)) ? lw_val_q : ram_rdata;
	assign new_min = (s1_info.first || (s1_dark < old_min)) ? s1_dark : old_min;

	// Finished tiles go to the result queue.
	assign s1_push = s1_vld && s1_info.emit;

	always_comb begin
		push_res.frame_end    = s1_info.frame_end;
		push_res.tile_row     = s1_info.tile_row;
		push_res.tile_column  = s1_info.idx;
		push_res.tile_minimum = new_min;
	end

	dctm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_push),
		.push_data (push_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (head_res),
		.count     (fifo_count)
	);

	assign m_tdata = {2'b00, head_res.tile_row, head_res.tile_column, head_res.tile_minimum};
	assign m_tlast = head_res.frame_end;

	// The result queue is never pushed when it is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_push |-> fifo_count < dctm_pkg::FIFO_CW'(dctm_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	// Every accepted pixel is written back to the memory in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_vld)
		else $error("accepted pixel lost before write-back");

	// The input only stalls while results are waiting at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	// After the last tile of a frame the position has wrapped to the origin.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld && s1_info.emit && s1_info.frame_end) |-> at_origin)
		else $error("position did not wrap at frame end");

endmodule
